// ===== hw/rtl/mndt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note duration tracker package
// Shared constants, payload word types and the decoded item type.
// ----------------------------------------------------------------------------
package mndt_pkg;

   localparam int TIME_BITS_DEF  = 48;
   localparam int BLOCK_BITS_DEF = 16;

   localparam int OUT_TIME_W  = 48;
   localparam int FRAMES_W    = 16;
   localparam int MIN_DUR_W   = 16;
   localparam int TABLE_DEPTH = 2048;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int VEL_W       = 7;

   localparam logic [MIN_DUR_W-1:0] MIN_DUR_RESET = 16'd48;

   localparam logic [7:0] KIND_MASK = 8'hF0;
   localparam logic [7:0] CHAN_MASK = 8'h0F;
   localparam logic [7:0] KIND_ON   = 8'h90;
   localparam logic [7:0] KIND_OFF  = 8'h80;

   localparam logic OP_MSG     = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef struct packed {
      logic                op;
      logic [7:0]          status_byte;
      logic [6:0]          note_number;
      logic [VEL_W-1:0]    velocity_in;
      logic [FRAMES_W-1:0] frames;
   } req_type;

   typedef struct packed {
      logic [OUT_TIME_W-1:0] start_frame;
      logic [6:0]            note_out;
      logic [3:0]            channel_out;
      logic [VEL_W-1:0]      velocity_out;
      logic [OUT_TIME_W-1:0] duration_frames;
   } rsp_type;

   // Decoded MIDI message held in the pairing stage.
   typedef struct packed {
      logic             note_on;
      logic             note_off;
      logic [6:0]       note;
      logic [3:0]       chan;
      logic [VEL_W-1:0] vel;
   } item_type;

endpackage

// ===== hw/rtl/mndt_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending note table
// Single-port write, registered read with write bypass, clearing sweep after
// reset.
// ----------------------------------------------------------------------------
module mndt_table #(
   parameter int TIME_BITS = mndt_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [mndt_pkg::TABLE_AW-1:0] rd_addr,
   output logic [TIME_BITS+mndt_pkg::VEL_W:0] rd_word,
   input  logic                          wr_en,
   input  logic [mndt_pkg::TABLE_AW-1:0] wr_addr,
   input  logic [TIME_BITS+mndt_pkg::VEL_W:0] wr_word,
   output logic                          busy
);
   import mndt_pkg::*;

   localparam int WordW = TIME_BITS + VEL_W + 1;

   logic [WordW-1:0]    mem_ff [TABLE_DEPTH];
   logic [WordW-1:0]    rd_word_ff;
   logic                clear_busy_ff, clear_busy_in;
   logic [TABLE_AW-1:0] clear_addr_ff, clear_addr_in;
   logic                mem_we;
   logic [TABLE_AW-1:0] mem_waddr;
   logic [WordW-1:0]    mem_wdata;

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == TABLE_AW'(TABLE_DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
      mem_we    = clear_busy_ff | wr_en;
      mem_waddr = clear_busy_ff ? clear_addr_ff : wr_addr;
      mem_wdata = clear_busy_ff ? '0 : wr_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   // A read that meets a write to the same entry returns the new contents.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_word_ff <= wr_word;
         end else begin
            rd_word_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_word = rd_word_ff;
   assign busy    = clear_busy_ff;

endmodule

// ===== hw/rtl/mndt_stamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time stamp and decode stage
// Keeps the frame counter, stamps and decodes accepted words.
// ----------------------------------------------------------------------------
module mndt_stamp #(
   parameter int TIME_BITS  = mndt_pkg::TIME_BITS_DEF,
   parameter int BLOCK_BITS = mndt_pkg::BLOCK_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          out_free,
   input  mndt_pkg::req_type             req_data,
   output logic [mndt_pkg::TABLE_AW-1:0] rd_addr,
   output logic                          s1_valid,
   output mndt_pkg::item_type            s1_item,
   output logic [TIME_BITS-1:0]          s1_stamp
);
   import mndt_pkg::*;

   localparam int UseBits = (BLOCK_BITS < FRAMES_W) ? BLOCK_BITS : FRAMES_W;

   logic [TIME_BITS-1:0] counter_ff, counter_in;
   logic [TIME_BITS-1:0] stamp_ff;
   logic [TIME_BITS-1:0] frames_used;
   logic [TIME_BITS-1:0] sum;
   logic                 valid_ff, valid_in;
   item_type             item_ff, item_in;
   logic [7:0]           kind;
   logic                 is_note_kind;

   always_comb begin
      frames_used  = TIME_BITS'(req_data.frames[UseBits-1:0]);
      sum          = counter_ff + frames_used;
      kind         = req_data.status_byte & KIND_MASK;
      is_note_kind = kind inside {KIND_ON, KIND_OFF};

      item_in.note     = req_data.note_number;
      item_in.chan     = 4'(req_data.status_byte & CHAN_MASK);
      item_in.vel      = req_data.velocity_in;
      item_in.note_on  = (kind == KIND_ON) && (req_data.velocity_in != '0);
      item_in.note_off = is_note_kind && !item_in.note_on;

      counter_in = counter_ff;
      if (accept && (req_data.op == OP_ADVANCE)) begin
         counter_in = sum;
      end

      valid_in = out_free ? 1'b0 : valid_ff;
      if (accept) begin
         valid_in = (req_data.op == OP_MSG) && is_note_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         counter_ff <= counter_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff  <= item_in;
         stamp_ff <= sum;
      end
   end

   assign rd_addr  = {item_in.chan, item_in.note};
   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;
   assign s1_stamp = stamp_ff;

endmodule

// ===== hw/rtl/mndt_pair.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note pairing stage
// Updates the table entry and forms the finished note in the result register.
// ----------------------------------------------------------------------------
module mndt_pair #(
   parameter int TIME_BITS = mndt_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            s1_valid,
   input  mndt_pkg::item_type              s1_item,
   input  logic [TIME_BITS-1:0]            s1_stamp,
   input  logic [TIME_BITS+mndt_pkg::VEL_W:0] rd_word,
   input  logic [mndt_pkg::MIN_DUR_W-1:0]  min_dur,
   input  logic                            rsp_ready,
   output logic                            out_free,
   output logic                            wr_en,
   output logic [mndt_pkg::TABLE_AW-1:0]   wr_addr,
   output logic [TIME_BITS+mndt_pkg::VEL_W:0] wr_word,
   output logic                            rsp_valid,
   output mndt_pkg::rsp_type               rsp_data
);
   import mndt_pkg::*;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 entry_valid;
   logic [TIME_BITS-1:0] entry_start;
   logic [VEL_W-1:0]     entry_vel;
   logic [TIME_BITS-1:0] diff;
   logic [TIME_BITS-1:0] min_ext;
   logic [TIME_BITS-1:0] dur;
   logic                 fire;
   logic                 hit;

   always_comb begin
      entry_valid = rd_word[TIME_BITS+VEL_W];
      entry_start = rd_word[VEL_W +: TIME_BITS];
      entry_vel   = rd_word[VEL_W-1:0];

      out_free = !rsp_valid_ff || rsp_ready;
      fire     = s1_valid && out_free;
      hit      = fire && s1_item.note_off && entry_valid;

      wr_en   = fire && (s1_item.note_on || (s1_item.note_off && entry_valid));
      wr_addr = {s1_item.chan, s1_item.note};
      wr_word = s1_item.note_on ? {1'b1, s1_stamp, s1_item.vel} : '0;

      diff    = s1_stamp - entry_start;
      min_ext = TIME_BITS'(min_dur);
      dur     = (diff < min_ext) ? min_ext : diff;

      rsp_in.start_frame     = OUT_TIME_W'(entry_start);
      rsp_in.note_out        = s1_item.note;
      rsp_in.channel_out     = s1_item.chan;
      rsp_in.velocity_out    = entry_vel;
      rsp_in.duration_frames = OUT_TIME_W'(dur);

      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (hit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/midi_note_duration_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note duration tracker
// Pairs note-on and note-off messages into finished notes in integer frames.
// ----------------------------------------------------------------------------
// The request channel takes one word per MIDI message or end-of-block advance;
// the response channel gives one word per finished note. Both use valid and
// ready. The CSR port writes the minimum reported duration at any edge where
// csr_wr_en is high, and should only be used while the block is idle.
//
// A word can be accepted in every cycle while req_ready is high. In the accept
// cycle the pending note table is read and the word is stamped, both into
// registers; once the pairing stage can move on, the entry is rewritten and a
// finished note is loaded into the response register, where it is offered to
// the receiver. A word that meets a table write to the same entry sees the
// new contents through a bypass.
//
// After reset all 2048 table entries are swept clear, one entry a cycle, with
// req_ready held low. When the receiver stalls, the response register holds
// its note and one further word can still be taken into the pairing stage;
// after that req_ready falls until the response is taken.
// ----------------------------------------------------------------------------
module midi_note_duration_tracker_core #(
   parameter int TIME_BITS  = mndt_pkg::TIME_BITS_DEF,
   parameter int BLOCK_BITS = mndt_pkg::BLOCK_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mndt_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mndt_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [mndt_pkg::MIN_DUR_W-1:0] csr_wr_data
);
   import mndt_pkg::*;

   localparam int WordW = TIME_BITS + VEL_W + 1;

   logic [MIN_DUR_W-1:0] min_dur_ff, min_dur_in;
   logic                 accept;
   logic                 out_free;
   logic                 table_busy;
   logic [TABLE_AW-1:0]  rd_addr;
   logic [WordW-1:0]     rd_word;
   logic                 wr_en;
   logic [TABLE_AW-1:0]  wr_addr;
   logic [WordW-1:0]     wr_word;
   logic                 s1_valid;
   item_type             s1_item;
   logic [TIME_BITS-1:0] s1_stamp;

   // The pairing stage must be free, or able to move on, before a new word
   // enters it; advance words only touch the counter but follow the same rule.
   assign req_ready = !table_busy && (!s1_valid || out_free);
   assign accept    = req_valid && req_ready;

   always_comb begin
      min_dur_in = csr_wr_en ? csr_wr_data : min_dur_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dur_ff <= MIN_DUR_RESET;
      end else begin
         min_dur_ff <= min_dur_in;
      end
   end

   mndt_stamp #(
      .TIME_BITS  (TIME_BITS),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_stamp (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .out_free (out_free),
      .req_data (req_data),
      .rd_addr  (rd_addr),
      .s1_valid (s1_valid),
      .s1_item  (s1_item),
      .s1_stamp (s1_stamp)
   );

   mndt_table #(
      .TIME_BITS (TIME_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_word (rd_word),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_word (wr_word),
      .busy    (table_busy)
   );

   mndt_pair #(
      .TIME_BITS (TIME_BITS)
   ) u_pair (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .s1_stamp  (s1_stamp),
      .rd_word   (rd_word),
      .min_dur   (min_dur_ff),
      .rsp_ready (rsp_ready),
      .out_free  (out_free),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_word   (wr_word),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/mndt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note duration tracker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mndt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mndt_pkg::rsp_type rsp_data
);
   import mndt_pkg::*;

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // The clearing sweep keeps requests out straight after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during table sweep");

   // Only entries written by a note-on are reported, so velocity is never zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.velocity_out != '0)
      else $error("finished note with zero velocity");

   // A new response follows an accepted request word.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

endmodule

bind midi_note_duration_tracker_core mndt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
